// ----- hw/rtl/scf_pkg.sv -----
// shared types and constants of the separable convolution filter
package scf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int TAPS_W   = 5;
	localparam int BANDS_W  = 3;
	localparam int LINE_W   = 12;
	localparam int HEIGHT_W = 16;
	localparam int SCALE_W  = 31;
	localparam int RES_W    = 48;
	localparam int CFG_W    = 48;
	localparam int CIDX_W   = 3;
	localparam int CI_W     = 4;
	localparam int ROW_W    = 16;

	localparam logic [CIDX_W-1:0] CFG_TAPS   = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_BANDS  = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_LINE   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_HEIGHT = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_SCALE  = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_OFFSET = 3'd5;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEFF  = 1'b1;

	localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VERT,
		ST_HORZ,
		ST_DIV,
		ST_PUT
	} state_t;

endpackage

// ----- hw/rtl/scf_vcell.sv -----
// vertical cell: one line store row, one tap product, partial sum hop
module scf_vcell #(
	parameter int MAX_LINE = 2048,
	parameter int COL_W    = 11,
	parameter int VS_W     = 37
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [COL_W-1:0]                    wr_addr,
	input  logic signed [scf_pkg::SAMPLE_W-1:0] wr_data,
	input  logic [COL_W-1:0]                    rd_addr,
	input  logic signed [scf_pkg::COEF_W-1:0]   coef,
	input  logic                                en,
	input  logic signed [VS_W-1:0]              psum_in,
	output logic signed [VS_W-1:0]              psum_out
);
	import scf_pkg::*;

	localparam int PROD_W = SAMPLE_W + COEF_W;

	logic signed [SAMPLE_W-1:0] mem [MAX_LINE];
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [PROD_W-1:0]   prod_s1;
	logic signed [VS_W-1:0]     psum_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// rows outside the mask give zero, stale data never enters the sum
	always_ff @(posedge clk) begin
		prod_s1 <= en ? PROD_W'(coef * rd_q) : '0;
		psum_q  <= psum_in + VS_W'(prod_s1);
	end

	assign psum_out = psum_q;

endmodule

// ----- hw/rtl/scf_hcell.sv -----
// horizontal cell: band-length delay of vertical sums, tap product, sum hop
module scf_hcell #(
	parameter int MAX_BANDS = 4,
	parameter int BI_W      = 2,
	parameter int VS_W      = 37,
	parameter int ACC_W     = 58
) (
	input  logic                              clk,
	input  logic                              shift,
	input  logic [BI_W-1:0]                   b_sel,
	input  logic signed [VS_W-1:0]            win_in,
	output logic signed [VS_W-1:0]            win_out,
	input  logic signed [scf_pkg::COEF_W-1:0] coef,
	input  logic                              en,
	input  logic signed [ACC_W-1:0]           psum_in,
	output logic signed [ACC_W-1:0]           psum_out
);
	import scf_pkg::*;

	localparam int PROD_W = VS_W + COEF_W;

	logic signed [VS_W-1:0]   st_q [MAX_BANDS];
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  psum_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			st_q[0] <= win_in;
			for (int i = 1; i < MAX_BANDS; i++) begin
				st_q[i] <= st_q[i-1];
			end
		end
	end

	// delay of one pixel per band before the next cell
	assign win_out = st_q[b_sel];

	always_ff @(posedge clk) begin
		prod_s1 <= en ? PROD_W'(coef * st_q[0]) : '0;
		psum_q  <= psum_in + ACC_W'(prod_s1);
	end

	assign psum_out = psum_q;

endmodule

// ----- hw/rtl/scf_div.sv -----
// radix-2 restoring divider, signed dividend, truncation toward zero
module scf_div #(
	parameter int W = 58
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [W-1:0]                dividend,
	input  logic [scf_pkg::SCALE_W-1:0]        divisor,
	output logic                               done,
	output logic signed [W-1:0]                quotient
);
	import scf_pkg::*;

	localparam int CW = $clog2(W);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic                 neg_q;
	logic [W-1:0]         q_q;
	logic [SCALE_W-1:0]   rem_q;
	logic [SCALE_W-1:0]   d_q;
	logic [SCALE_W:0]     trial;
	logic                 ge;
	logic [SCALE_W-1:0]   rem_n;
	logic [W-1:0]         mag;

	assign mag   = dividend[W-1] ? W'(-dividend) : W'(dividend);
	assign trial = {rem_q, q_q[W-1]};
	assign ge    = trial >= {1'b0, d_q};
	assign rem_n = ge ? SCALE_W'(trial - {1'b0, d_q}) : trial[SCALE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= mag;
			rem_q <= '0;
			neg_q <= dividend[W-1];
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			q_q   <= {q_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? W'(-$signed(q_q)) : $signed(q_q);

endmodule

// ----- hw/rtl/separable_convolution_filter_core.sv -----
// top level of the separable convolution filter: control, cell chains, divider
// sequencer steps: coefficient items and samples above the first full window
//   leave it idle; a sample with a vertical sum passes through ST_VERT; a sample
//   with a result passes through ST_VERT, ST_HORZ, ST_DIV and ST_PUT
// throughput: one item at a time, set by the partial-sum hop along the cells
//   and the one-bit-per-cycle divider
// reset: counters, coefficients, registers to defaults; line store not cleared
module separable_convolution_filter_core #(
	parameter int MAX_TAPS  = 16,
	parameter int MAX_LINE  = 2048,
	parameter int MAX_BANDS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [scf_pkg::SAMPLE_W-1:0] sample,
	input  logic [scf_pkg::CI_W-1:0]            coeff_index,
	input  logic signed [scf_pkg::COEF_W-1:0]   coeff_value,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [scf_pkg::RES_W-1:0]    result,
	output logic [$clog2(MAX_LINE)-1:0]         out_col,
	output logic [scf_pkg::ROW_W-1:0]           out_row,
	output logic                                end_of_frame,
	// configuration
	input  logic                                cfg_we,
	input  logic [scf_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [scf_pkg::CFG_W-1:0]           cfg_data
);
	import scf_pkg::*;

	localparam int COL_W  = $clog2(MAX_LINE);
	localparam int TI_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TN_W   = $clog2(MAX_TAPS + 1);
	localparam int BI_W   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int BN_W   = $clog2(MAX_BANDS + 1);
	localparam int LN_W   = $clog2(MAX_LINE + 1);
	localparam int VS_W   = SAMPLE_W + COEF_W + $clog2(MAX_TAPS + 1);
	localparam int ACC_W  = VS_W + COEF_W + $clog2(MAX_TAPS + 1);
	localparam int SUM_W  = ACC_W + 1;
	localparam int LAT    = MAX_TAPS + 3;
	localparam int CNT_W  = $clog2(LAT + 1);

	// configuration registers
	logic [TAPS_W-1:0]          taps_q;
	logic [BANDS_W-1:0]         bands_q;
	logic [LINE_W-1:0]          line_q;
	logic [HEIGHT_W-1:0]        height_q;
	logic [SCALE_W-1:0]         scale_q;
	logic signed [RES_W-1:0]    offset_q;

	logic signed [COEF_W-1:0]   coeff_q [MAX_TAPS];

	// raster position
	logic [COL_W-1:0]           col_q;
	logic [ROW_W-1:0]           row_q;
	logic [TI_W-1:0]            row_ptr_q;

	// item in flight
	logic [COL_W-1:0]           c_q;
	logic [TN_W-1:0]            n_q;
	logic [BI_W-1:0]            bsel_q;
	logic [TI_W-1:0]            top_ptr_q;
	logic                       horz_en_q;
	logic [COL_W-1:0]           first_q;
	logic [ROW_W-1:0]           top_q;
	logic                       eof_q;

	state_t                     state_q, state_d;
	logic [CNT_W-1:0]           cnt_q;

	logic                       accept;
	logic                       acc_sample;
	logic                       shift_en;
	logic                       div_start;
	logic                       div_done;
	logic                       load_out;

	// effective geometry, out-of-range values clamped
	logic [TN_W-1:0]            n_eff;
	logic [BN_W-1:0]            b_eff;
	logic [LN_W-1:0]            w_eff;
	logic [HEIGHT_W-1:0]        h_eff;
	int                         span;
	int                         tp;
	logic                       vert_en;
	logic                       horz_en;
	logic                       last_col;
	logic                       last_row;

	logic signed [VS_W-1:0]     vpsum [MAX_TAPS];
	logic signed [VS_W-1:0]     hwin  [MAX_TAPS];
	logic signed [ACC_W-1:0]    hpsum [MAX_TAPS];

	logic signed [ACC_W-1:0]    quot;
	logic signed [SUM_W-1:0]    sum;
	logic [SCALE_W-1:0]         divisor;

	logic                       out_valid_q;
	logic signed [RES_W-1:0]    result_q;
	logic [COL_W-1:0]           out_col_q;
	logic [ROW_W-1:0]           out_row_q;
	logic                       eof_out_q;

	assign accept     = in_valid && !in_stall;
	assign acc_sample = accept && (op == OP_SAMPLE);

	always_comb begin
		if (taps_q == '0) begin
			n_eff = TN_W'(1);
		end else if (32'(taps_q) > MAX_TAPS) begin
			n_eff = TN_W'(MAX_TAPS);
		end else begin
			n_eff = TN_W'(taps_q);
		end
		if (bands_q == '0) begin
			b_eff = BN_W'(1);
		end else if (32'(bands_q) > MAX_BANDS) begin
			b_eff = BN_W'(MAX_BANDS);
		end else begin
			b_eff = BN_W'(bands_q);
		end
		if (line_q == '0) begin
			w_eff = LN_W'(1);
		end else if (32'(line_q) > MAX_LINE) begin
			w_eff = LN_W'(MAX_LINE);
		end else begin
			w_eff = LN_W'(line_q);
		end
		h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;

		span     = (32'(n_eff) - 1) * 32'(b_eff);
		vert_en  = (32'(row_q) + 1) >= 32'(n_eff);
		horz_en  = 32'(col_q) >= span;
		last_col = (32'(col_q) + 1) >= 32'(w_eff);
		last_row = (32'(row_q) + 1) >= 32'(h_eff);

		// line store row that holds the top of the window
		tp = 32'(row_ptr_q) + MAX_TAPS - (32'(n_eff) - 1);
		if (tp >= MAX_TAPS) begin
			tp = tp - MAX_TAPS;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q   <= TAPS_W'(3);
			bands_q  <= BANDS_W'(1);
			line_q   <= LINE_W'(2048);
			height_q <= HEIGHT_W'(1);
			scale_q  <= SCALE_W'(1);
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAPS:   taps_q   <= cfg_data[TAPS_W-1:0];
				CFG_BANDS:  bands_q  <= cfg_data[BANDS_W-1:0];
				CFG_LINE:   line_q   <= cfg_data[LINE_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				CFG_OFFSET: offset_q <= $signed(cfg_data[RES_W-1:0]);
				default: ;
			endcase
		end
	end

	// coefficient table, index at or beyond MAX_TAPS ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TAPS; i++) begin
				coeff_q[i] <= '0;
			end
		end else if (accept && (op == OP_COEFF) && (32'(coeff_index) < MAX_TAPS)) begin
			coeff_q[TI_W'(coeff_index)] <= coeff_value;
		end
	end

	// raster counters advance on every sample item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			row_ptr_q <= '0;
		end else if (acc_sample) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q     <= '0;
					row_ptr_q <= '0;
				end else begin
					row_q     <= row_q + 1'b1;
					row_ptr_q <= (32'(row_ptr_q) == MAX_TAPS - 1) ? '0 : row_ptr_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// snapshot of the sample item being filtered
	always_ff @(posedge clk) begin
		if (acc_sample) begin
			c_q       <= col_q;
			n_q       <= n_eff;
			bsel_q    <= BI_W'(b_eff - 1'b1);
			top_ptr_q <= TI_W'(tp);
			horz_en_q <= horz_en;
			first_q   <= COL_W'(32'(col_q) - span);
			top_q     <= ROW_W'(32'(row_q) + 1 - 32'(n_eff));
			eof_q     <= last_col && last_row;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_sample && vert_en) begin
					state_d = ST_VERT;
				end
			end
			ST_VERT: begin
				if (cnt_q == CNT_W'(LAT - 1)) begin
					state_d = horz_en_q ? ST_HORZ : ST_IDLE;
				end
			end
			ST_HORZ: begin
				if (cnt_q == CNT_W'(LAT - 1)) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		shift_en  = (state_q == ST_VERT) && (cnt_q == CNT_W'(LAT - 1));
		div_start = (state_q == ST_HORZ) && (cnt_q == CNT_W'(LAT - 1));
		load_out  = (state_q == ST_PUT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == ST_VERT || state_q == ST_HORZ) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// vertical chain: one cell per line store row, sum hops one cell a cycle
	for (genvar p = 0; p < MAX_TAPS; p++) begin : g_vcell
		int                       kv;
		logic                     ven;
		logic signed [COEF_W-1:0] vcoef;
		logic signed [VS_W-1:0]   vin;

		always_comb begin
			kv = p + MAX_TAPS - 32'(top_ptr_q);
			if (kv >= MAX_TAPS) begin
				kv = kv - MAX_TAPS;
			end
			ven   = kv < 32'(n_q);
			vcoef = coeff_q[TI_W'(kv)];
		end

		if (p == 0) begin : g_head
			assign vin = '0;
		end else begin : g_link
			assign vin = vpsum[p-1];
		end

		scf_vcell #(
			.MAX_LINE (MAX_LINE),
			.COL_W    (COL_W),
			.VS_W     (VS_W)
		) u_vcell (
			.clk      (clk),
			.we       (acc_sample && (32'(row_ptr_q) == p)),
			.wr_addr  (col_q),
			.wr_data  (sample),
			.rd_addr  (c_q),
			.coef     (vcoef),
			.en       (ven),
			.psum_in  (vin),
			.psum_out (vpsum[p])
		);
	end

	// horizontal chain: cell j sees the vertical sum j times the band count pixels back
	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_hcell
		logic                     hen;
		logic signed [COEF_W-1:0] hcoef;
		logic signed [VS_W-1:0]   win;
		logic signed [ACC_W-1:0]  hin;

		always_comb begin
			hen   = j < 32'(n_q);
			hcoef = hen ? coeff_q[TI_W'(32'(n_q) - 1 - j)] : '0;
		end

		if (j == 0) begin : g_head
			assign win = vpsum[MAX_TAPS-1];
			assign hin = '0;
		end else begin : g_link
			assign win = hwin[j-1];
			assign hin = hpsum[j-1];
		end

		scf_hcell #(
			.MAX_BANDS (MAX_BANDS),
			.BI_W      (BI_W),
			.VS_W      (VS_W),
			.ACC_W     (ACC_W)
		) u_hcell (
			.clk      (clk),
			.shift    (shift_en),
			.b_sel    (bsel_q),
			.win_in   (win),
			.win_out  (hwin[j]),
			.coef     (hcoef),
			.en       (hen),
			.psum_in  (hin),
			.psum_out (hpsum[j])
		);
	end

	// divide by the scale, zero acts as one
	assign divisor = (scale_q == '0) ? SCALE_W'(1) : scale_q;

	scf_div #(
		.W (ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (hpsum[MAX_TAPS-1]),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quot)
	);

	// offset and saturation into the output register
	assign sum = SUM_W'(quot) + SUM_W'(offset_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (sum > SUM_W'(RES_MAX)) begin
				result_q <= RES_MAX;
			end else if (sum < SUM_W'(RES_MIN)) begin
				result_q <= RES_MIN;
			end else begin
				result_q <= RES_W'(sum);
			end
			out_col_q <= first_q;
			out_row_q <= top_q;
			eof_out_q <= eof_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result       = result_q;
	assign out_col      = out_col_q;
	assign out_row      = out_row_q;
	assign end_of_frame = eof_out_q;

endmodule

// ----- hw/rtl/scf_checker.sv -----
// port-level checks of the separable convolution filter and their binding
module scf_checker #(
	parameter int COL_W = 11
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                op,
	input logic signed [scf_pkg::SAMPLE_W-1:0] sample,
	input logic [scf_pkg::CI_W-1:0]            coeff_index,
	input logic signed [scf_pkg::COEF_W-1:0]   coeff_value,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [scf_pkg::RES_W-1:0]    result,
	input logic [COL_W-1:0]                    out_col,
	input logic [scf_pkg::ROW_W-1:0]           out_row,
	input logic                                end_of_frame,
	input logic                                cfg_we,
	input logic [scf_pkg::CIDX_W-1:0]          cfg_index,
	input logic [scf_pkg::CFG_W-1:0]           cfg_data
);
	import scf_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result) && $stable(out_col)
			&& $stable(out_row) && $stable(end_of_frame))
		else $error("stalled result changed");

	// the input is not stalled in the cycle after a coefficient item is taken
	a_coeff_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_COEFF) |=> !in_stall)
		else $error("coefficient item stalled the input");

	// no result can appear right after an item is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after an item");

endmodule

bind separable_convolution_filter_core scf_checker #(
	.COL_W ($clog2(MAX_LINE))
) u_scf_checker (.*);

// ----- sim/tb_top.sv -----
// self-checking testbench for the separable convolution filter core
`timescale 1ns / 1ps

module tb_top;
	import scf_pkg::*;

	localparam int MAX_TAPS  = 16;
	localparam int MAX_LINE  = 2048;
	localparam int MAX_BANDS = 4;
	localparam int WIN_DEPTH = MAX_TAPS * MAX_BANDS;
	localparam int COL_W     = $clog2(MAX_LINE);
	// worst busy time of one item without a result, plus margin
	localparam int DRAIN_CYCLES = 200;

	// one item on the input channel
	typedef struct {
		logic                       op;
		logic signed [SAMPLE_W-1:0] sample;
		logic [CI_W-1:0]            idx;
		logic signed [COEF_W-1:0]   value;
	} filter_item_t;

	// one filtered element as the block should give it
	typedef struct {
		logic signed [RES_W-1:0] result;
		logic [COL_W-1:0]        col;
		logic [ROW_W-1:0]        row;
		logic                    eof;
	} pixel_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       op;
	logic signed [SAMPLE_W-1:0] sample;
	logic [CI_W-1:0]            coeff_index;
	logic signed [COEF_W-1:0]   coeff_value;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [RES_W-1:0]    result;
	logic [COL_W-1:0]           out_col;
	logic [ROW_W-1:0]           out_row;
	logic                       end_of_frame;
	logic                       cfg_we;
	logic [CIDX_W-1:0]          cfg_index;
	logic [CFG_W-1:0]           cfg_data;

	separable_convolution_filter_core #(
		.MAX_TAPS(MAX_TAPS),
		.MAX_LINE(MAX_LINE),
		.MAX_BANDS(MAX_BANDS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.sample(sample),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result),
		.out_col(out_col),
		.out_row(out_row),
		.end_of_frame(end_of_frame),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// stimulus and scoreboard storage
	filter_item_t pending_items[$];
	pixel_t       expected_pixels[$];
	int           pushed_count;
	int           accepted_count;
	int           error_count;
	int           random_count;
	bit           running;
	bit           calm;
	bit           in_took;
	int           in_gap;
	int           out_gap;

	// shadow of the filter state
	int unsigned             m_taps, m_bands, m_line, m_height, m_scale;
	longint                  m_offset;
	logic signed [15:0]      m_rows [MAX_TAPS][MAX_LINE];
	logic signed [15:0]      m_coeff [MAX_TAPS];
	longint                  m_vsum [WIN_DEPTH];
	int unsigned             m_col, m_row;

	pixel_t                  pred;
	bit                      pred_got;
	pixel_t                  seen;

	function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// run one accepted item through the shadow filter
	task automatic convolve_element(input filter_item_t it, output bit got, output pixel_t px);
		int unsigned n, b, w, h, c, r, span, top, first;
		longint vs, acc, res;
		got = 1'b0;
		px = '{default: '0};
		if (it.op == OP_COEFF) begin
			m_coeff[it.idx] = it.value;
			return;
		end
		n = clamp_u(m_taps, 1, MAX_TAPS);
		b = clamp_u(m_bands, 1, MAX_BANDS);
		w = clamp_u(m_line, 1, MAX_LINE);
		h = clamp_u(m_height, 1, 65535);
		c = m_col % MAX_LINE;
		r = m_row;
		m_rows[r % MAX_TAPS][c] = it.sample;
		if (r + 1 >= n) begin
			top = r + 1 - n;
			vs = 0;
			// vertical pass down the column
			for (int k = 0; k < n; k++)
				vs += longint'(m_coeff[k]) * longint'(m_rows[(top + k) % MAX_TAPS][c]);
			m_vsum[c % WIN_DEPTH] = vs;
			span = (n - 1) * b;
			if (c >= span) begin
				first = c - span;
				acc = 0;
				// horizontal pass over same-band vertical sums
				for (int k = 0; k < n; k++)
					acc += longint'(m_coeff[k]) * m_vsum[(first + k * b) % WIN_DEPTH];
				res = acc / longint'(m_scale == 0 ? 1 : m_scale) + m_offset;
				if (res > longint'(RES_MAX)) res = longint'(RES_MAX);
				if (res < longint'(RES_MIN)) res = longint'(RES_MIN);
				px.result = res[RES_W-1:0];
				px.col = first[COL_W-1:0];
				px.row = top[ROW_W-1:0];
				px.eof = (c + 1 >= w) && (r + 1 >= h);
				got = 1'b1;
			end
		end
		// raster counters wrap at line and frame end
		if (c + 1 >= w) begin
			m_col = 0;
			m_row = (r + 1 >= h) ? 0 : ((r + 1) & 16'hFFFF);
		end else begin
			m_col = (c + 1) & 11'h7FF;
		end
	endtask

	task automatic report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// monitor: check results first, then predict the item accepted at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					report($sformatf("unexpected result %0d at col %0d row %0d",
						result, out_col, out_row));
				end else begin
					seen = expected_pixels.pop_front();
					if (result !== seen.result)
						report($sformatf("result %0d, want %0d", result, seen.result));
					if (out_col !== seen.col)
						report($sformatf("out_col %0d, want %0d", out_col, seen.col));
					if (out_row !== seen.row)
						report($sformatf("out_row %0d, want %0d", out_row, seen.row));
					if (end_of_frame !== seen.eof)
						report($sformatf("end_of_frame %0b, want %0b", end_of_frame, seen.eof));
				end
			end
			if (in_valid && !in_stall) begin
				accepted_count++;
				convolve_element('{op, sample, coeff_index, coeff_value}, pred_got, pred);
				if (pred_got)
					expected_pixels.push_back(pred);
			end
		end
		in_took <= arst_n && in_valid && !in_stall;
	end

	// input driver: holds the payload while stalled, idles in random bursts unless calm
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (running && pending_items.size() > 0) begin
				if (!calm && $urandom_range(0, 19) == 0) begin
					in_gap <= $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else begin
					op <= pending_items[0].op;
					sample <= pending_items[0].sample;
					coeff_index <= pending_items[0].idx;
					coeff_value <= pending_items[0].value;
					void'(pending_items.pop_front());
					in_valid <= 1'b1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output back-pressure in random bursts unless calm
	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			out_gap <= $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// register write, mirrored into the shadow configuration
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			CFG_TAPS:   m_taps = data[TAPS_W-1:0];
			CFG_BANDS:  m_bands = data[BANDS_W-1:0];
			CFG_LINE:   m_line = data[LINE_W-1:0];
			CFG_HEIGHT: m_height = data[HEIGHT_W-1:0];
			CFG_SCALE:  m_scale = data[SCALE_W-1:0];
			CFG_OFFSET: m_offset = longint'($signed(data[RES_W-1:0]));
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic setup(input int unsigned t, input int unsigned b, input int unsigned l,
			input int unsigned h, input int unsigned s, input longint o);
		write_reg(CFG_TAPS, CFG_W'(t));
		write_reg(CFG_BANDS, CFG_W'(b));
		write_reg(CFG_LINE, CFG_W'(l));
		write_reg(CFG_HEIGHT, CFG_W'(h));
		write_reg(CFG_SCALE, CFG_W'(s));
		write_reg(CFG_OFFSET, o[CFG_W-1:0]);
	endtask

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
		pending_items.push_back('{OP_SAMPLE, s, CI_W'($urandom), COEF_W'($urandom)});
		pushed_count++;
	endtask

	task automatic push_coeff(input logic [CI_W-1:0] i, input logic signed [COEF_W-1:0] v);
		pending_items.push_back('{OP_COEFF, SAMPLE_W'($urandom), i, v});
		pushed_count++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return '0;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// wait until every item is in and every result is out, then let the core go idle
	task automatic settle();
		while (accepted_count < pushed_count || expected_pixels.size() > 0 || in_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// whole frames of random samples, mixed with random coefficient items, at the current geometry
	task automatic run_frames(input int frames, input int rows);
		int unsigned w;
		w = clamp_u(m_line, 1, MAX_LINE);
		for (int f = 0; f < frames; f++)
			for (int y = 0; y < rows; y++)
				for (int x = 0; x < w; x++) begin
					if ($urandom_range(0, 24) == 0) begin
						push_coeff(CI_W'($urandom), COEF_W'($urandom));
						random_count++;
					end
					push_sample(pick_sample());
					random_count++;
				end
	endtask

	initial begin
		int unsigned t, b, n, bb, w, h, l, hv, s;
		longint o;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_SAMPLE;
		sample = '0;
		coeff_index = '0;
		coeff_value = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TAPS;
		cfg_data = '0;
		in_took = 1'b0;
		in_gap = 0;
		out_gap = 0;
		running = 1'b0;
		calm = 1'b0;
		pushed_count = 0;
		accepted_count = 0;
		error_count = 0;
		random_count = 0;
		m_taps = 3; m_bands = 1; m_line = 2048; m_height = 1;
		m_scale = 1; m_offset = 0;
		m_col = 0; m_row = 0;
		foreach (m_coeff[i]) m_coeff[i] = '0;
		foreach (m_vsum[i]) m_vsum[i] = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		running = 1'b1;

		// directed: 3x3 mask on a 4x3 frame with extreme coefficients and samples
		setup(3, 1, 4, 3, 1, 0);
		push_coeff(0, 16'sd32767);
		push_coeff(1, -16'sd32768);
		push_coeff(2, 16'sd4096);
		push_coeff(15, -16'sd1);
		for (int i = 0; i < 12; i++)
			push_sample(i % 2 ? -16'sd32768 : 16'sd32767);
		settle();

		// directed: saturation at both ends, scale of zero acting as one
		setup(1, 1, 2, 1, 0, longint'(RES_MAX));
		push_coeff(0, -16'sd32768);
		push_sample(-16'sd32768);
		push_sample(16'sd32767);
		settle();
		setup(0, 0, 0, 0, 1, longint'(RES_MIN));
		push_sample(16'sd32767);
		push_sample(-16'sd32768);
		settle();

		// random geometry, mask and arithmetic settings
		while (random_count < 520) begin
			if ($urandom_range(0, 9) == 0) begin
				t = $urandom_range(0, 1) ? 0 : $urandom_range(6, 31);
				b = $urandom_range(0, 1);
			end else begin
				t = $urandom_range(1, 5);
				b = $urandom_range(0, 7);
			end
			n = clamp_u(t, 1, MAX_TAPS);
			bb = clamp_u(b, 1, MAX_BANDS);
			w = $urandom_range(0, 7) == 0 ? $urandom_range(1, (n - 1) * bb + 1)
				: (n - 1) * bb + 1 + $urandom_range(0, 5);
			h = $urandom_range(0, 7) == 0 ? $urandom_range(1, n) : n + $urandom_range(0, 2);
			l = (w == 1 && $urandom_range(0, 1)) ? 0 : w;
			hv = (h == 1 && $urandom_range(0, 1)) ? 0 : h;
			case ($urandom_range(0, 4))
				0: s = 0;
				1: s = 1;
				2: s = 32'h7FFF_FFFF;
				default: s = $urandom_range(1, 1 << $urandom_range(0, 30));
			endcase
			case ($urandom_range(0, 4))
				0: o = 0;
				1: o = longint'(RES_MAX);
				2: o = longint'(RES_MIN);
				default: o = longint'($signed(48'({$urandom, $urandom}))) >>> $urandom_range(0, 40);
			endcase
			setup(t, b, l, hv, s, o);
			for (int i = $urandom_range(0, 4); i > 0; i--)
				push_coeff(CI_W'($urandom), COEF_W'($urandom));
			run_frames($urandom_range(1, 2), h);
			settle();
		end

		// tallest frame height with the widest mask, first 17 rows only, no idling on either side
		calm = 1'b1;
		setup(31, 1, 16, 65535, 32'h7FFF_FFFF, 0);
		for (int i = 0; i < MAX_TAPS; i++)
			push_coeff(CI_W'(i), COEF_W'($urandom));
		run_frames(1, 17);

		while (accepted_count < pushed_count || expected_pixels.size() > 0 || in_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_pixels.size() > 0)
			report($sformatf("%0d results never arrived", expected_pixels.size()));
		if (error_count == 0) begin
			$display("separable_convolution_filter_core regression: pass");
		end else begin
			$display("separable_convolution_filter_core regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("separable_convolution_filter_core regression: fail");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/scf_pkg.sv
hw/rtl/scf_vcell.sv
hw/rtl/scf_hcell.sv
hw/rtl/scf_div.sv
hw/rtl/separable_convolution_filter_core.sv
hw/rtl/scf_checker.sv
sim/tb_top.sv
